// ----- hdl/bcd_clock_set_menu_defines.svh -----
// ----------------------------------------------------------------------------
// bcd_clock_set_menu_defines
// assertion macros shared by the checker
// ----------------------------------------------------------------------------
`ifndef BCD_CLOCK_SET_MENU_DEFINES_SVH
`define BCD_CLOCK_SET_MENU_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define BCSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define BCSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/bcsm_pkg.sv -----
// ----------------------------------------------------------------------------
// bcsm_pkg
// types, codes and helper functions of the bcd clock set menu
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcsm_pkg;

   localparam int unsigned NUM_FIELDS = 6;
   localparam int unsigned FIELD_W    = 3;
   localparam int unsigned VALUE_W    = 8;
   localparam int unsigned KEY_W      = 3;

   localparam logic [FIELD_W-1:0] LAST_FIELD = FIELD_W'(NUM_FIELDS - 1);

   localparam logic CMD_KEY  = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [KEY_W-1:0] KEY_ABORT   = 3'd1;
   localparam logic [KEY_W-1:0] KEY_CONFIRM = 3'd2;
   localparam logic [KEY_W-1:0] KEY_UP      = 3'd3;
   localparam logic [KEY_W-1:0] KEY_DOWN    = 3'd4;

   localparam logic [FIELD_W-1:0] FLD_YEAR   = 3'd0;
   localparam logic [FIELD_W-1:0] FLD_MONTH  = 3'd1;
   localparam logic [FIELD_W-1:0] FLD_DAY    = 3'd2;
   localparam logic [FIELD_W-1:0] FLD_HOUR   = 3'd3;
   localparam logic [FIELD_W-1:0] FLD_MINUTE = 3'd4;
   localparam logic [FIELD_W-1:0] FLD_SECOND = 3'd5;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MENU = 2'd1,
      MODE_EDIT = 2'd2
   } mode_type;

   typedef struct packed {
      logic               wr_en;
      logic [FIELD_W-1:0] wr_sel;
      logic [VALUE_W-1:0] wr_data;
      logic [FIELD_W-1:0] rd_sel;
   } store_ctrl_type;

   typedef struct packed {
      logic [VALUE_W-1:0] edit_value;
      logic [FIELD_W-1:0] edit_field;
      logic [1:0]         menu_mode;
      logic [VALUE_W-1:0] write_data;
      logic [VALUE_W-1:0] write_address;
      logic               write_valid;
   } result_type;

   function automatic logic [VALUE_W-1:0] clock_addr(input logic [FIELD_W-1:0] fld);
      logic [VALUE_W-1:0] addr;
      case (fld)
         FLD_YEAR:   addr = 8'h8C;
         FLD_MONTH:  addr = 8'h88;
         FLD_DAY:    addr = 8'h86;
         FLD_HOUR:   addr = 8'h84;
         FLD_MINUTE: addr = 8'h82;
         FLD_SECOND: addr = 8'h80;
         default:    addr = 8'h00;
      endcase
      return addr;
   endfunction

   // step a bcd byte by one modulo 100, nibbles read as tens and units
   function automatic logic [VALUE_W-1:0] bcd_step(input logic [VALUE_W-1:0] v,
                                                   input logic up);
      logic [7:0]  n;
      logic [7:0]  m;
      logic [15:0] prod;
      logic [3:0]  tens;
      logic [7:0]  tens_x10;
      logic [7:0]  units;
      n = ({4'd0, v[7:4]} * 8'd10) + {4'd0, v[3:0]};
      if (up) begin
         m = n + 8'd1;
      end else if (n == 8'd0) begin
         m = 8'd100;
      end else begin
         m = n - 8'd1;
      end
      if (m >= 8'd100) begin
         m = m - 8'd100;
      end
      if (!up && n == 8'd0) begin
         m = 8'd99;
      end
      // divide by ten via reciprocal, exact for m below 160
      prod     = {8'd0, m} * 16'd205;
      tens     = prod[14:11];
      tens_x10 = {4'd0, tens} * 8'd10;
      units    = m - tens_x10;
      return {tens, units[3:0]};
   endfunction

endpackage

// ----- hdl/bcsm_time_store.sv -----
// ----------------------------------------------------------------------------
// bcsm_time_store
// six stored bcd time fields, one write port and one read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcsm_time_store (
   input  logic                              clock,
   input  logic                              reset,
   input  bcsm_pkg::store_ctrl_type          ctrl,
   output logic [bcsm_pkg::VALUE_W-1:0]      rd_data
);

   logic [bcsm_pkg::VALUE_W-1:0] time_ff [bcsm_pkg::NUM_FIELDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < int'(bcsm_pkg::NUM_FIELDS); i++) begin
            time_ff[i] <= '0;
         end
      end else if (ctrl.wr_en && ctrl.wr_sel < bcsm_pkg::FIELD_W'(bcsm_pkg::NUM_FIELDS)) begin
         time_ff[ctrl.wr_sel] <= ctrl.wr_data;
      end
   end

   always_comb begin
      if (ctrl.rd_sel < bcsm_pkg::FIELD_W'(bcsm_pkg::NUM_FIELDS)) begin
         rd_data = time_ff[ctrl.rd_sel];
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ----- hdl/bcsm_menu_fsm.sv -----
// ----------------------------------------------------------------------------
// bcsm_menu_fsm
// menu state, edit cursor and working value; forms one result per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcsm_menu_fsm (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  logic                              command,
   input  logic [bcsm_pkg::KEY_W-1:0]        key_code,
   input  logic [bcsm_pkg::FIELD_W-1:0]      field_select,
   input  logic [bcsm_pkg::VALUE_W-1:0]      field_value,
   input  logic [bcsm_pkg::VALUE_W-1:0]      store_rd_data,
   output bcsm_pkg::store_ctrl_type          store_ctrl,
   output bcsm_pkg::result_type              result
);

   bcsm_pkg::mode_type               mode_ff, mode_in;
   logic [bcsm_pkg::FIELD_W-1:0]     cursor_ff, cursor_in;
   logic [bcsm_pkg::VALUE_W-1:0]     work_ff, work_in;
   // mirror of the stored value under the cursor
   logic [bcsm_pkg::VALUE_W-1:0]     ref_ff, ref_in;
   logic                             is_load;
   logic                             is_key;
   logic                             commit;

   assign is_load = step_en && command == bcsm_pkg::CMD_LOAD;
   assign is_key  = step_en && command == bcsm_pkg::CMD_KEY;
   assign commit  = is_key && mode_ff == bcsm_pkg::MODE_EDIT
                    && key_code == bcsm_pkg::KEY_CONFIRM && work_ff != ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bcsm_pkg::MODE_IDLE;
         cursor_ff <= '0;
         work_ff   <= '0;
         ref_ff    <= '0;
      end else begin
         mode_ff   <= mode_in;
         cursor_ff <= cursor_in;
         work_ff   <= work_in;
         ref_ff    <= ref_in;
      end
   end

   // next state
   always_comb begin
      mode_in   = mode_ff;
      cursor_in = cursor_ff;
      work_in   = work_ff;
      ref_in    = ref_ff;
      if (is_load) begin
         if (field_select == cursor_ff) begin
            ref_in = field_value;
         end
      end else if (is_key) begin
         case (mode_ff)
            bcsm_pkg::MODE_IDLE: begin
               if (key_code == bcsm_pkg::KEY_ABORT) begin
                  mode_in = bcsm_pkg::MODE_MENU;
               end
            end
            bcsm_pkg::MODE_MENU: begin
               if (key_code == bcsm_pkg::KEY_ABORT) begin
                  mode_in = bcsm_pkg::MODE_IDLE;
               end else if (key_code == bcsm_pkg::KEY_CONFIRM) begin
                  mode_in   = bcsm_pkg::MODE_EDIT;
                  cursor_in = '0;
                  work_in   = store_rd_data;
                  ref_in    = store_rd_data;
               end
            end
            bcsm_pkg::MODE_EDIT: begin
               if (key_code == bcsm_pkg::KEY_ABORT) begin
                  mode_in   = bcsm_pkg::MODE_IDLE;
                  cursor_in = '0;
                  work_in   = '0;
               end else if (key_code == bcsm_pkg::KEY_CONFIRM) begin
                  if (cursor_ff == bcsm_pkg::LAST_FIELD) begin
                     mode_in   = bcsm_pkg::MODE_MENU;
                     cursor_in = '0;
                     work_in   = '0;
                  end else begin
                     cursor_in = cursor_ff + 1'b1;
                     work_in   = store_rd_data;
                     ref_in    = store_rd_data;
                  end
               end else if (key_code == bcsm_pkg::KEY_UP) begin
                  work_in = bcsm_pkg::bcd_step(work_ff, 1'b1);
               end else if (key_code == bcsm_pkg::KEY_DOWN) begin
                  work_in = bcsm_pkg::bcd_step(work_ff, 1'b0);
               end
            end
            default: begin
               mode_in = bcsm_pkg::MODE_IDLE;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      store_ctrl.wr_en   = is_load || commit;
      store_ctrl.wr_sel  = is_load ? field_select : cursor_ff;
      store_ctrl.wr_data = is_load ? field_value : work_ff;
      store_ctrl.rd_sel  = (mode_ff == bcsm_pkg::MODE_EDIT) ? cursor_ff + 1'b1 : '0;

      result.write_valid   = commit;
      result.write_address = commit ? bcsm_pkg::clock_addr(cursor_ff) : '0;
      result.write_data    = commit ? work_ff : '0;
      result.menu_mode     = mode_in;
      result.edit_field    = (mode_in == bcsm_pkg::MODE_EDIT) ? cursor_in : '0;
      result.edit_value    = (mode_in == bcsm_pkg::MODE_EDIT) ? work_in : '0;
   end

endmodule

// ----- hdl/bcd_clock_set_menu.sv -----
// a result is shown on rsp the cycle after its item is accepted
// throughput: one item per cycle unless rsp stalls; the menu state register updates once per transfer
// the output register takes a new item whenever it is empty or being drained
// reset clears the menu state, the six stored time fields and the output valid
// ----------------------------------------------------------------------------
// bcd_clock_set_menu
// key driven time setting menu over six bcd clock fields
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_clock_set_menu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // key_code[2:0], field_select[5:3], field_value[13:6]
   input  logic        req_tuser,   // command[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // write_address[7:0], write_data[15:8],
                                    // menu_mode[17:16], edit_field[20:18], edit_value[28:21]
   output logic        rsp_tuser    // write_valid[0]
);

   logic                         accept;
   logic                         rsp_valid_ff, rsp_valid_in;
   bcsm_pkg::result_type         rsp_ff;
   bcsm_pkg::result_type         result;
   bcsm_pkg::store_ctrl_type     store_ctrl;
   logic [bcsm_pkg::VALUE_W-1:0] store_rd_data;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   bcsm_time_store u_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (store_ctrl),
      .rd_data (store_rd_data)
   );

   bcsm_menu_fsm u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step_en       (accept),
      .command       (req_tuser),
      .key_code      (req_tdata[2:0]),
      .field_select  (req_tdata[5:3]),
      .field_value   (req_tdata[13:6]),
      .store_rd_data (store_rd_data),
      .store_ctrl    (store_ctrl),
      .result        (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.write_valid;
   assign rsp_tdata  = {3'd0, rsp_ff.edit_value, rsp_ff.edit_field, rsp_ff.menu_mode,
                        rsp_ff.write_data, rsp_ff.write_address};

endmodule

// ----- hdl/bcsm_checker.sv -----
// ----------------------------------------------------------------------------
// bcsm_checker
// port level checks of the bcd clock set menu, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bcd_clock_set_menu_defines.svh"

module bcsm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic [1:0]  rsp_mode;
   logic [7:0]  rsp_addr;
   logic [32:0] rsp_word;
   logic        rsp_stall;
   logic        rsp_write;
   logic        rsp_nowrite;
   logic        rsp_noedit;
   logic        rsp_in_menu;
   logic        rsp_addr_ok;

   assign rsp_mode    = rsp_tdata[17:16];
   assign rsp_addr    = rsp_tdata[7:0];
   assign rsp_word    = {rsp_tuser, rsp_tdata};
   assign rsp_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_write   = rsp_tvalid && rsp_tuser;
   assign rsp_nowrite = rsp_tvalid && !rsp_tuser;
   assign rsp_noedit  = rsp_tvalid && rsp_mode != bcsm_pkg::MODE_EDIT;
   assign rsp_in_menu = rsp_mode == bcsm_pkg::MODE_MENU || rsp_mode == bcsm_pkg::MODE_EDIT;
   assign rsp_addr_ok = rsp_addr == 8'h8C || rsp_addr == 8'h88 || rsp_addr == 8'h86
                        || rsp_addr == 8'h84 || rsp_addr == 8'h82 || rsp_addr == 8'h80;

   `BCSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word), "rsp not held")

   `BCSM_ASSERT_NOW(a_write_in_menu, clock, reset, rsp_write, rsp_in_menu, "write outside the menu")

   `BCSM_ASSERT_NOW(a_write_addr, clock, reset, rsp_write, rsp_addr_ok, "bad clock write address")

   `BCSM_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_nowrite, rsp_tdata[15:0] == 16'd0, "stray write")

   `BCSM_ASSERT_NOW(a_edit_zero, clock, reset, rsp_noedit, rsp_tdata[28:18] == 11'd0, "stray edit")

endmodule

bind bcd_clock_set_menu bcsm_checker u_bcsm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
